### rtl/swse_pkg.sv
`timescale 1ns / 1ps

package swse_pkg;

    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_VALUE_BITS   = 24;
    localparam int DEF_TIME_BITS    = 32;

    localparam int WL_BITS     = 7;
    localparam int WL_RESET    = 12;
    localparam int SLOPE_BITS  = 32;
    localparam int STATUS_BITS = 3;

    // normalized span of the window and the bits of a normalized time
    localparam int NORM_SPAN = 310000;
    localparam int NORM_BITS = $clog2(NORM_SPAN + 1);

    // Q8.24 result: integer bits, plus one extra fraction bit for rounding
    localparam int Q_INT_BITS   = 8;
    localparam int Q_FRAC_STEPS = 25;

    typedef enum logic [STATUS_BITS-1:0] {
        FIT_OK    = 3'd0,
        FIT_SMALL = 3'd1,
        FIT_FLAT  = 3'd2,
        FIT_ORDER = 3'd3,
        FIT_SPAN  = 3'd4
    } fit_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_ACCUM,
        ST_PROD,
        ST_DIFF,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### rtl/swse_ram.sv
`timescale 1ns / 1ps

module swse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/swse_norm_div.sv
`timescale 1ns / 1ps

module swse_norm_div #(
    parameter int TIME_BITS  = swse_pkg::DEF_TIME_BITS,
    parameter int VALUE_BITS = swse_pkg::DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [TIME_BITS-1:0]                in_d,
    input  logic signed [VALUE_BITS-1:0]        in_y,
    input  logic [TIME_BITS-1:0]                span,
    output logic                                out_valid,
    output logic [swse_pkg::NORM_BITS-1:0]      out_x,
    output logic signed [VALUE_BITS-1:0]        out_y
);
    import swse_pkg::*;

    localparam int XB = NORM_BITS;
    localparam int PW = TIME_BITS + XB;

    logic [PW-1:0] prod;

    logic                         v_reg   [0:XB];
    logic [TIME_BITS-1:0]         rem_reg [0:XB];
    logic [XB-1:0]                low_reg [0:XB];
    logic [XB-1:0]                q_reg   [0:XB];
    logic signed [VALUE_BITS-1:0] y_reg   [0:XB];

    logic [TIME_BITS:0] r2_c  [0:XB-1];
    logic [TIME_BITS:0] sub_c [0:XB-1];
    logic               ge_c  [0:XB-1];

    logic                         ov_reg;
    logic [XB-1:0]                x_reg;
    logic signed [VALUE_BITS-1:0] yo_reg;
    logic                         round_up;

    assign prod = PW'(in_d) * PW'(NORM_SPAN);

    always_comb begin
        for (int s = 0; s < XB; s++) begin
            r2_c[s]  = {rem_reg[s], low_reg[s][XB-1]};
            ge_c[s]  = (r2_c[s] >= {1'b0, span});
            sub_c[s] = r2_c[s] - {1'b0, span};
        end
    end

    assign round_up = ({rem_reg[XB], 1'b0} >= {1'b0, span});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= XB; s++) begin
                v_reg[s] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end else begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= XB; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
            ov_reg <= v_reg[XB];
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg[0] <= prod[PW-1:XB];
        low_reg[0] <= prod[XB-1:0];
        q_reg[0]   <= '0;
        y_reg[0]   <= in_y;
        for (int s = 1; s <= XB; s++) begin
            rem_reg[s] <= ge_c[s-1] ? sub_c[s-1][TIME_BITS-1:0] : r2_c[s-1][TIME_BITS-1:0];
            low_reg[s] <= {low_reg[s-1][XB-2:0], 1'b0};
            q_reg[s]   <= {q_reg[s-1][XB-2:0], ge_c[s-1]};
            y_reg[s]   <= y_reg[s-1];
        end
        x_reg  <= q_reg[XB] + XB'(round_up);
        yo_reg <= y_reg[XB];
    end

    assign out_valid = ov_reg;
    assign out_x     = x_reg;
    assign out_y     = yo_reg;

endmodule

### rtl/swse_q824_div.sv
`timescale 1ns / 1ps

module swse_q824_div #(
    parameter int NUMW = 60,
    parameter int DENW = 52
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [NUMW-1:0]                 num,
    input  logic [DENW-1:0]                        den,
    output logic                                   done,
    output logic signed [swse_pkg::SLOPE_BITS-1:0] slope
);
    import swse_pkg::*;

    localparam int QB   = Q_INT_BITS + Q_FRAC_STEPS;
    localparam int CNTW = $clog2(QB + 1);
    localparam int CW   = (NUMW > DENW + Q_INT_BITS) ? NUMW : DENW + Q_INT_BITS;

    logic                  busy_reg, prep_reg, done_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  neg_reg, sat_reg;
    logic [NUMW-1:0]       mag_reg;
    logic [DENW-1:0]       den_reg, rem_reg;
    logic [QB-1:0]         low_reg, q_reg;
    logic [SLOPE_BITS-1:0] slope_reg;

    logic [DENW:0] r2, diff;
    logic          ge;
    logic [QB:0]   rinc;
    logic [QB-1:0] rounded, lim, mag_out;

    assign r2   = {rem_reg, low_reg[QB-1]};
    assign diff = r2 - {1'b0, den_reg};
    assign ge   = (r2 >= {1'b0, den_reg});

    assign rinc    = {1'b0, q_reg} + (QB+1)'(1);
    assign rounded = rinc[QB:1];
    assign lim     = neg_reg ? (QB'(1) << (SLOPE_BITS - 1))
                             : ((QB'(1) << (SLOPE_BITS - 1)) - QB'(1));
    assign mag_out = (sat_reg || rounded > lim) ? lim : rounded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            prep_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                prep_reg <= 1'b1;
            end else if (busy_reg && prep_reg) begin
                prep_reg <= 1'b0;
                cnt_reg  <= CNTW'(QB);
            end else if (busy_reg && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNTW'(1);
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NUMW-1];
            mag_reg <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
            den_reg <= den;
        end else if (busy_reg && prep_reg) begin
            sat_reg <= (CW'(mag_reg) >= (CW'(den_reg) << Q_INT_BITS));
            rem_reg <= DENW'(mag_reg >> Q_INT_BITS);
            low_reg <= {mag_reg[Q_INT_BITS-1:0], {Q_FRAC_STEPS{1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= ge ? diff[DENW-1:0] : r2[DENW-1:0];
            low_reg <= {low_reg[QB-2:0], 1'b0};
            q_reg   <= {q_reg[QB-2:0], ge};
        end else if (busy_reg) begin
            slope_reg <= neg_reg ? SLOPE_BITS'(-mag_out) : SLOPE_BITS'(mag_out);
        end
    end

    assign done  = done_reg;
    assign slope = slope_reg;

endmodule

### rtl/sliding_window_slope_estimator.sv
`timescale 1ns / 1ps

// Least-squares slope over the newest window_length samples, reported in Q8.24 per
// normalized time unit (the window span maps to 310000). Samples sit in one
// single-port-read RAM; a push is stored in the cycle it is accepted. A clear, a
// push that does not yet fill the window, or a push into a window of at most one
// sample goes straight to the output register with no fit. A push that fits makes
// one RAM pass for the flat, time-order and span checks, a second pass through a
// 21-stage pipelined time normalizer and the accumulators, then four products and
// a 33-step bit-serial divider for the final Q8.24 quotient. The input is taken
// only while the sequencer is idle; the output register lets one result wait while
// the next word is processed.
module sliding_window_slope_estimator #(
    parameter int WINDOW_DEPTH = swse_pkg::DEF_WINDOW_DEPTH,
    parameter int VALUE_BITS   = swse_pkg::DEF_VALUE_BITS,
    parameter int TIME_BITS    = swse_pkg::DEF_TIME_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [swse_pkg::WL_BITS-1:0]           cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic [TIME_BITS-1:0]                   s_sample_time,
    input  logic signed [VALUE_BITS-1:0]           s_sample_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_slope_valid,
    output logic signed [swse_pkg::SLOPE_BITS-1:0] m_slope,
    output logic [swse_pkg::STATUS_BITS-1:0]       m_fit_status
);
    import swse_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int NW   = $clog2(WINDOW_DEPTH + 1);
    localparam int PCW  = $clog2(WINDOW_DEPTH + 2);
    localparam int MW   = TIME_BITS + VALUE_BITS;
    localparam int XB   = NORM_BITS;
    localparam int SXW  = XB + NW;
    localparam int SXXW = 2 * XB + NW;
    localparam int SYW  = VALUE_BITS + NW;
    localparam int SXYW = XB + 1 + VALUE_BITS + NW;
    localparam int P1W  = NW + 1 + SXYW;
    localparam int P2W  = SXW + 1 + SYW;
    localparam int NUMW = ((P1W > P2W) ? P1W : P2W) + 1;
    localparam int DENW = NW + SXXW;

    state_t state_reg, state_next;

    logic [WL_BITS-1:0] wl_reg;
    logic [AW-1:0]      wp_reg, newest_reg, oldest_reg, rd_ptr_reg;
    logic [PCW-1:0]     pc_reg;
    logic [NW-1:0]      n_reg, iss_reg, rtag_reg, acc_cnt_reg;
    logic               rv_reg;

    logic [TIME_BITS-1:0]         t0_reg, tl_reg, span_reg;
    logic signed [VALUE_BITS-1:0] yref_reg;
    logic                         flat_reg, order_bad_reg;

    logic                          mv_reg;
    logic [XB-1:0]                 x_m_reg;
    logic [2*XB-1:0]               xx_m_reg;
    logic signed [XB+VALUE_BITS:0] xy_m_reg;
    logic signed [VALUE_BITS-1:0]  y_m_reg;

    logic [SXW-1:0]         sx_reg;
    logic [SXXW-1:0]        sxx_reg;
    logic signed [SYW-1:0]  sy_reg;
    logic signed [SXYW-1:0] sxy_reg;

    logic signed [P1W-1:0] p1_reg;
    logic signed [P2W-1:0] p2_reg;
    logic [NW+SXXW-1:0]    p3_reg;
    logic [2*SXW-1:0]      p4_reg;

    logic                         res_valid_reg;
    logic signed [SLOPE_BITS-1:0] res_slope_reg;
    fit_status_t                  res_status_reg;

    logic                         m_valid_reg, m_slope_valid_reg;
    logic signed [SLOPE_BITS-1:0] m_slope_reg;
    fit_status_t                  m_status_reg;

    logic                 accept, fit_go, out_load;
    logic [NW-1:0]        w_eff;
    logic [PCW-1:0]       pc_next;
    logic [AW-1:0]        wp_next, oldest_calc, rd_ptr_inc;
    logic [AW+1:0]        old_sum;
    fit_status_t          check_status;

    logic                         ram_rd_en;
    logic [AW-1:0]                ram_rd_addr;
    logic [MW-1:0]                ram_rd_data;
    logic [TIME_BITS-1:0]         rd_t;
    logic signed [VALUE_BITS-1:0] rd_y;

    logic                         nd_in_valid, nd_out_valid;
    logic [XB-1:0]                nd_x;
    logic signed [VALUE_BITS-1:0] nd_y;

    logic                         div_start, div_done;
    logic signed [NUMW-1:0]       div_num;
    logic [DENW-1:0]              div_den;
    logic signed [SLOPE_BITS-1:0] div_slope;

    assign accept = s_valid && s_ready;

    assign w_eff   = (int'(wl_reg) > WINDOW_DEPTH) ? NW'(WINDOW_DEPTH) : NW'(wl_reg);
    assign pc_next = (int'(pc_reg) < WINDOW_DEPTH + 1) ? pc_reg + PCW'(1) : pc_reg;
    assign fit_go  = (int'(pc_next) > int'(w_eff));
    assign wp_next = (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + AW'(1);

    assign old_sum = (AW+2)'(wp_reg) + (AW+2)'(WINDOW_DEPTH + 1) - (AW+2)'(w_eff);
    assign oldest_calc = (old_sum >= (AW+2)'(WINDOW_DEPTH))
                       ? AW'(old_sum - (AW+2)'(WINDOW_DEPTH)) : AW'(old_sum);
    assign rd_ptr_inc = (rd_ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);

    assign rd_t = ram_rd_data[MW-1:VALUE_BITS];
    assign rd_y = $signed(ram_rd_data[VALUE_BITS-1:0]);

    always_comb begin
        priority if (flat_reg) begin
            check_status = FIT_FLAT;
        end else if (tl_reg < t0_reg || order_bad_reg) begin
            check_status = FIT_ORDER;
        end else if (tl_reg == t0_reg) begin
            check_status = FIT_SPAN;
        end else begin
            check_status = FIT_OK;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign div_num = NUMW'(p1_reg) - NUMW'(p2_reg);
    assign div_den = DENW'(p3_reg) - DENW'(p4_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_action && fit_go && w_eff > NW'(1)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (iss_reg == n_reg && !rv_reg) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (check_status == FIT_OK) ? ST_ACCUM : ST_DONE;
            end
            ST_ACCUM: begin
                if (acc_cnt_reg == n_reg) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_ptr_reg;
        nd_in_valid = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                ram_rd_en = (iss_reg != n_reg);
                if (iss_reg == '0) begin
                    ram_rd_addr = newest_reg;
                end
            end
            ST_ACCUM: begin
                ram_rd_en   = (iss_reg != n_reg);
                nd_in_valid = rv_reg;
            end
            ST_DIFF: begin
                div_start = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wl_reg      <= WL_BITS'(WL_RESET);
            wp_reg      <= '0;
            pc_reg      <= '0;
            iss_reg     <= '0;
            rv_reg      <= 1'b0;
            acc_cnt_reg <= '0;
            mv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= ram_rd_en;
            mv_reg    <= nd_out_valid;
            if (cfg_wr_en) begin
                wl_reg <= cfg_wr_data;
            end
            if (accept) begin
                if (s_action) begin
                    wp_reg <= '0;
                    pc_reg <= '0;
                end else begin
                    wp_reg <= wp_next;
                    pc_reg <= pc_next;
                end
            end
            if (state_reg == ST_IDLE || state_reg == ST_CHECK) begin
                iss_reg <= '0;
            end else if (ram_rd_en) begin
                iss_reg <= iss_reg + NW'(1);
            end
            if (state_reg == ST_CHECK) begin
                acc_cnt_reg <= '0;
            end else if (mv_reg) begin
                acc_cnt_reg <= acc_cnt_reg + NW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rtag_reg <= iss_reg;

        if (accept) begin
            n_reg          <= w_eff;
            newest_reg     <= wp_reg;
            oldest_reg     <= oldest_calc;
            rd_ptr_reg     <= oldest_calc;
            res_valid_reg  <= !s_action && fit_go;
            res_slope_reg  <= '0;
            res_status_reg <= (!s_action && fit_go && w_eff <= NW'(1)) ? FIT_SMALL : FIT_OK;
        end

        // first pass: newest sample, then oldest onward
        if (state_reg == ST_SCAN) begin
            if (ram_rd_en && iss_reg != '0) begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            if (rv_reg) begin
                if (rtag_reg == '0) begin
                    tl_reg        <= rd_t;
                    yref_reg      <= rd_y;
                    flat_reg      <= 1'b1;
                    order_bad_reg <= 1'b0;
                end else begin
                    if (rd_y != yref_reg) begin
                        flat_reg <= 1'b0;
                    end
                    if (rtag_reg == NW'(1)) begin
                        t0_reg <= rd_t;
                    end else if (rd_t < t0_reg || rd_t > tl_reg) begin
                        order_bad_reg <= 1'b1;
                    end
                end
            end
        end

        if (state_reg == ST_CHECK) begin
            span_reg   <= tl_reg - t0_reg;
            rd_ptr_reg <= oldest_reg;
            sx_reg     <= '0;
            sxx_reg    <= '0;
            sy_reg     <= '0;
            sxy_reg    <= '0;
            if (check_status != FIT_OK) begin
                res_status_reg <= check_status;
            end
        end

        if (state_reg == ST_ACCUM && ram_rd_en) begin
            rd_ptr_reg <= rd_ptr_inc;
        end

        x_m_reg  <= nd_x;
        xx_m_reg <= nd_x * nd_x;
        xy_m_reg <= $signed({1'b0, nd_x}) * nd_y;
        y_m_reg  <= nd_y;

        if (mv_reg) begin
            sx_reg  <= sx_reg + SXW'(x_m_reg);
            sxx_reg <= sxx_reg + SXXW'(xx_m_reg);
            sy_reg  <= sy_reg + SYW'(y_m_reg);
            sxy_reg <= sxy_reg + SXYW'(xy_m_reg);
        end

        if (state_reg == ST_PROD) begin
            p1_reg <= $signed({1'b0, n_reg}) * sxy_reg;
            p2_reg <= $signed({1'b0, sx_reg}) * sy_reg;
            p3_reg <= n_reg * sxx_reg;
            p4_reg <= sx_reg * sx_reg;
        end

        if (state_reg == ST_DIV && div_done) begin
            res_slope_reg  <= div_slope;
            res_status_reg <= FIT_OK;
        end

        if (out_load) begin
            m_slope_valid_reg <= res_valid_reg;
            m_slope_reg       <= res_slope_reg;
            m_status_reg      <= res_status_reg;
        end
    end

    swse_ram #(
        .WIDTH (MW),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (accept && !s_action),
        .wr_addr (wp_reg),
        .wr_data ({s_sample_time, s_sample_value}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    swse_norm_div #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (nd_in_valid),
        .in_d      (rd_t - t0_reg),
        .in_y      (rd_y),
        .span      (span_reg),
        .out_valid (nd_out_valid),
        .out_x     (nd_x),
        .out_y     (nd_y)
    );

    swse_q824_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_qdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .slope   (div_slope)
    );

    assign m_valid       = m_valid_reg;
    assign m_slope_valid = m_slope_valid_reg;
    assign m_slope       = m_slope_reg;
    assign m_fit_status  = m_status_reg;

endmodule
